[src/mpvf_pkg.sv]
// Shared types, constants and control structs for the median position/velocity filter.
package mpvf_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int WINDOW_LEN = 5;
    localparam int AXES       = 3;
    localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int RANK_W     = SLOT_W;
    localparam int WEIGHT_W   = 9;
    localparam int PROD_W     = SAMPLE_W + WEIGHT_W + 2;
    localparam int STEP_W     = PROD_W - 8;

    localparam logic [RANK_W-1:0]   MED_RANK    = RANK_W'(WINDOW_LEN / 2);
    localparam logic [SLOT_W-1:0]   SLOT_LAST   = SLOT_W'(WINDOW_LEN - 1);
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = WEIGHT_W'(256);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST  = WEIGHT_W'(51);

    localparam logic signed [SAMPLE_W:0] V_MAX =
        (SAMPLE_W + 1)'(signed'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1));
    localparam logic signed [SAMPLE_W:0] V_MIN =
        (SAMPLE_W + 1)'(signed'(-(64'sd1 <<< (SAMPLE_W - 1))));
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(128);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] window_t;
    typedef logic [WEIGHT_W-1:0] weight_t;

    typedef struct packed {
        logic              ld1;
        logic              ld2;
        logic              ld3;
        logic              ld4;
        logic [SLOT_W-1:0] slot;
    } lane_ctl_t;

endpackage

[src/mpvf_channels.sv]
// Valid/ready channel interfaces for samples, estimates and the weight register.
interface mpvf_sample_if;
    logic                valid;
    logic                ready;
    mpvf_pkg::sample_t   x_position;
    mpvf_pkg::sample_t   y_position;
    mpvf_pkg::sample_t   heading_angle;

    modport source (output valid, output x_position, output y_position,
                    output heading_angle, input ready);
    modport sink   (input valid, input x_position, input y_position,
                    input heading_angle, output ready);
endinterface

interface mpvf_estimate_if;
    logic                valid;
    logic                ready;
    mpvf_pkg::sample_t   x_median;
    mpvf_pkg::sample_t   y_median;
    mpvf_pkg::sample_t   heading_median;
    mpvf_pkg::sample_t   x_velocity;
    mpvf_pkg::sample_t   y_velocity;
    mpvf_pkg::sample_t   heading_rate;

    modport source (output valid, output x_median, output y_median,
                    output heading_median, output x_velocity, output y_velocity,
                    output heading_rate, input ready);
    modport sink   (input valid, input x_median, input y_median,
                    input heading_median, input x_velocity, input y_velocity,
                    input heading_rate, output ready);
endinterface

interface mpvf_weight_if;
    logic                valid;
    logic                ready;
    mpvf_pkg::weight_t   smoothing_weight;

    modport source (output valid, output smoothing_weight, input ready);
    modport sink   (input valid, input smoothing_weight, output ready);
endinterface

[src/median_position_velocity_filter.sv]
// Top level: three axis lanes under one four-stage valid/ready pipeline control.
// Takes one sample item per clock while the output is not stalled and returns one
// estimate item per sample. Each axis keeps a ring of the last five samples (zeros
// after reset), reports their median and a velocity smoothed by smoothing_weight/256
// (values above 256 act as 256). The rate is set by the velocity recurrence: one
// 10x25-bit multiply per lane that closes on its own register. Write smoothing_weight
// only while no item is in flight.
module median_position_velocity_filter
(
    input  logic                   clk,
    input  logic                   rst_n,
    mpvf_sample_if.sink            samples,
    mpvf_estimate_if.source        estimates,
    mpvf_weight_if.sink            settings
);

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic v4_reg, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;

    logic [mpvf_pkg::SLOT_W-1:0] slot_reg;
    logic [mpvf_pkg::SLOT_W-1:0] slot_next;
    mpvf_pkg::weight_t           weight_reg;
    mpvf_pkg::weight_t           weight_eff;
    mpvf_pkg::lane_ctl_t         ctl;

    mpvf_pkg::sample_t sample [mpvf_pkg::AXES];
    mpvf_pkg::sample_t med    [mpvf_pkg::AXES];
    mpvf_pkg::sample_t vel    [mpvf_pkg::AXES];

    // stage handshake chain
    always_comb
    begin
        rdy4      = !v4_reg || estimates.ready;
        rdy3      = !v3_reg || rdy4;
        rdy2      = !v2_reg || rdy3;
        rdy1      = !v1_reg || rdy2;
        ctl.ld1   = samples.valid && rdy1;
        ctl.ld2   = v1_reg && rdy2;
        ctl.ld3   = v2_reg && rdy3;
        ctl.ld4   = v3_reg && rdy4;
        ctl.slot  = slot_reg;
        v1_next   = ctl.ld1 || (v1_reg && !rdy2);
        v2_next   = ctl.ld2 || (v2_reg && !rdy3);
        v3_next   = ctl.ld3 || (v3_reg && !rdy4);
        v4_next   = ctl.ld4 || (v4_reg && !estimates.ready);
        slot_next = slot_reg;
        if (ctl.ld1)
        begin
            slot_next = (slot_reg == mpvf_pkg::SLOT_LAST) ? '0 : slot_reg + 1'b1;
        end
        weight_eff = (weight_reg > mpvf_pkg::WEIGHT_FULL) ? mpvf_pkg::WEIGHT_FULL
                                                          : weight_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
            slot_reg   <= '0;
            weight_reg <= mpvf_pkg::WEIGHT_RST;
        end
        else
        begin
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            v3_reg   <= v3_next;
            v4_reg   <= v4_next;
            slot_reg <= slot_next;
            if (settings.valid && settings.ready)
            begin
                weight_reg <= settings.smoothing_weight;
            end
        end
    end

    assign samples.ready  = rdy1;
    assign settings.ready = 1'b1;

    assign sample[0] = samples.x_position;
    assign sample[1] = samples.y_position;
    assign sample[2] = samples.heading_angle;

    for (genvar a = 0; a < mpvf_pkg::AXES; a++)
    begin : g_lane
        mpvf_lane u_lane
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .sample (sample[a]),
            .weight (weight_eff),
            .med    (med[a]),
            .vel    (vel[a])
        );
    end

    assign estimates.valid          = v4_reg;
    assign estimates.x_median       = med[0];
    assign estimates.y_median       = med[1];
    assign estimates.heading_median = med[2];
    assign estimates.x_velocity     = vel[0];
    assign estimates.y_velocity     = vel[1];
    assign estimates.heading_rate   = vel[2];

`ifndef NO_ASSERTIONS
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> v1_reg)
        else $error("accepted item did not enter the first stage");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= mpvf_pkg::SLOT_LAST)
        else $error("ring slot out of range");

    a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(samples.valid && samples.ready) |=> $stable(slot_reg))
        else $error("ring slot moved without an item");

    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !v4_reg) |-> ctl.ld4)
        else $error("item held before an empty output stage");
`endif

endmodule

[src/mpvf_median.sv]
// Rank-select median of one window: parallel pairwise compares, pick the middle rank.
module mpvf_median
(
    input  mpvf_pkg::window_t win,
    output mpvf_pkg::sample_t med
);

    logic [mpvf_pkg::RANK_W-1:0] rank [mpvf_pkg::WINDOW_LEN];

    always_comb
    begin
        logic                        lt;
        logic [mpvf_pkg::RANK_W-1:0] cnt;
        for (int i = 0; i < mpvf_pkg::WINDOW_LEN; i++)
        begin
            cnt = '0;
            for (int j = 0; j < mpvf_pkg::WINDOW_LEN; j++)
            begin
                lt = ($signed(win[j]) < $signed(win[i])) ||
                     ((win[j] == win[i]) && (j < i));
                cnt = cnt + mpvf_pkg::RANK_W'(lt);
            end
            rank[i] = cnt;
        end
    end

    always_comb
    begin
        med = '0;
        for (int i = 0; i < mpvf_pkg::WINDOW_LEN; i++)
        begin
            if (rank[i] == mpvf_pkg::MED_RANK)
            begin
                med = $signed(win[i]);
            end
        end
    end

endmodule

[src/mpvf_lane.sv]
// One axis lane: sample ring, median stage, raw difference stage, smoothing stage.
module mpvf_lane
(
    input  logic                clk,
    input  logic                rst_n,
    input  mpvf_pkg::lane_ctl_t ctl,
    input  mpvf_pkg::sample_t   sample,
    input  mpvf_pkg::weight_t   weight,
    output mpvf_pkg::sample_t   med,
    output mpvf_pkg::sample_t   vel
);

    mpvf_pkg::window_t win_reg;
    mpvf_pkg::sample_t med_now;
    mpvf_pkg::sample_t med2_reg;
    mpvf_pkg::sample_t med3_reg;
    mpvf_pkg::sample_t raw3_reg;
    mpvf_pkg::sample_t raw3_next;
    mpvf_pkg::sample_t med4_reg;
    mpvf_pkg::sample_t vel4_reg;
    mpvf_pkg::sample_t vel4_next;

    logic signed [mpvf_pkg::SAMPLE_W:0]   diff_med;
    logic signed [mpvf_pkg::SAMPLE_W:0]   diff_vel;
    logic signed [mpvf_pkg::PROD_W-1:0]   prod;
    logic signed [mpvf_pkg::STEP_W-1:0]   step;
    logic signed [mpvf_pkg::STEP_W-1:0]   vel_sum;

    mpvf_median u_median
    (
        .win (win_reg),
        .med (med_now)
    );

    // write the new sample into the ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (ctl.ld1)
        begin
            win_reg[ctl.slot] <= sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld2)
        begin
            med2_reg <= med_now;
        end
    end

    // saturated change of the median
    always_comb
    begin
        diff_med = {med2_reg[mpvf_pkg::SAMPLE_W-1], med2_reg}
                 - {med3_reg[mpvf_pkg::SAMPLE_W-1], med3_reg};
        if (diff_med > mpvf_pkg::V_MAX)
        begin
            raw3_next = mpvf_pkg::V_MAX[mpvf_pkg::SAMPLE_W-1:0];
        end
        else if (diff_med < mpvf_pkg::V_MIN)
        begin
            raw3_next = mpvf_pkg::V_MIN[mpvf_pkg::SAMPLE_W-1:0];
        end
        else
        begin
            raw3_next = diff_med[mpvf_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            med3_reg <= '0;
        end
        else if (ctl.ld3)
        begin
            med3_reg <= med2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld3)
        begin
            raw3_reg <= raw3_next;
        end
    end

    // old + round((raw - old) * w / 256); stays inside the 24-bit range
    always_comb
    begin
        diff_vel  = {raw3_reg[mpvf_pkg::SAMPLE_W-1], raw3_reg}
                  - {vel4_reg[mpvf_pkg::SAMPLE_W-1], vel4_reg};
        prod      = $signed({1'b0, weight}) * diff_vel;
        prod      = prod + mpvf_pkg::ROUND_HALF;
        step      = prod[mpvf_pkg::PROD_W-1:8];
        vel_sum   = mpvf_pkg::STEP_W'(vel4_reg) + step;
        vel4_next = vel_sum[mpvf_pkg::SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel4_reg <= '0;
        end
        else if (ctl.ld4)
        begin
            vel4_reg <= vel4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld4)
        begin
            med4_reg <= med3_reg;
        end
    end

    assign med = med4_reg;
    assign vel = vel4_reg;

endmodule

[tb/sv/tb_median_position_velocity_filter.sv]
// Testbench for the median position/velocity filter: stimulus table and random samples.
module tb_median_position_velocity_filter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 225;
    localparam int REPORT_LIMIT  = 10;

    localparam longint SAT_HI = (64'sd1 <<< (mpvf_pkg::SAMPLE_W - 1)) - 64'sd1;
    localparam longint SAT_LO = -(64'sd1 <<< (mpvf_pkg::SAMPLE_W - 1));

    typedef enum int {
        STYLE_NOISE,
        STYLE_WALK,
        STYLE_SPIKY_WALK,
        STYLE_EXTREME
    } sample_style_t;

    typedef struct packed {
        logic              at_rest;
        mpvf_pkg::sample_t x;
        mpvf_pkg::sample_t y;
        mpvf_pkg::sample_t h;
    } table_row_t;

    typedef struct packed {
        mpvf_pkg::sample_t [mpvf_pkg::AXES-1:0] med;
        mpvf_pkg::sample_t [mpvf_pkg::AXES-1:0] vel;
    } estimate_t;

    localparam int DIRECTED_ROWS = 18;
    localparam table_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{1'b1, 24'h7FFFFF, 24'h800000, 24'hFFFFFF},
        '{1'b1, 24'h7FFFFF, 24'h800000, 24'hFFFFFF},
        '{1'b0, 24'h7FFFFF, 24'h800000, 24'hFFFFFF},
        '{1'b0, 24'h7FFFFF, 24'h800000, 24'hFFFFFF},
        '{1'b0, 24'h7FFFFF, 24'h800000, 24'hFFFFFF},
        '{1'b0, 24'h800000, 24'h7FFFFF, 24'h000000},
        '{1'b0, 24'h800000, 24'h7FFFFF, 24'h000000},
        '{1'b0, 24'h800000, 24'h7FFFFF, 24'h000000},
        '{1'b0, 24'h800000, 24'h7FFFFF, 24'h000000},
        '{1'b0, 24'h800000, 24'h7FFFFF, 24'h000000},
        '{1'b0, 24'h000000, 24'h000000, 24'h7FFFFF},
        '{1'b0, 24'h000001, 24'hFFFFFF, 24'h800000},
        '{1'b0, 24'h555555, 24'hAAAAAA, 24'h000100},
        '{1'b0, 24'hAAAAAA, 24'h555555, 24'hFFFF00},
        '{1'b0, 24'h000100, 24'h000200, 24'h000300},
        '{1'b0, 24'h7F0000, 24'h810000, 24'h000080},
        '{1'b0, 24'h000100, 24'h000200, 24'h000300},
        '{1'b0, 24'h000101, 24'h000201, 24'h000301}
    };

    logic clk = 1'b0;
    logic rst_n;

    mpvf_sample_if   samp ();
    mpvf_estimate_if est ();
    mpvf_weight_if   cfg ();

    median_position_velocity_filter DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samp),
        .estimates (est),
        .settings  (cfg)
    );

    always #HALF_PERIOD clk = ~clk;

    mpvf_pkg::sample_t ring [mpvf_pkg::AXES][mpvf_pkg::WINDOW_LEN];
    int                ring_slot;
    mpvf_pkg::sample_t last_median [mpvf_pkg::AXES];
    mpvf_pkg::sample_t last_velocity [mpvf_pkg::AXES];
    mpvf_pkg::weight_t weight_reg;

    table_row_t sample_queue [$];
    estimate_t  estimate_queue [$];
    int         samples_queued;
    int         samples_accepted;
    int         error_count;
    int         idle_pct;
    bit         steady;
    int         stalled_cycles;

    function automatic mpvf_pkg::sample_t clamp24(longint v);
        if (v > SAT_HI)
            return mpvf_pkg::sample_t'(SAT_HI);
        if (v < SAT_LO)
            return mpvf_pkg::sample_t'(SAT_LO);
        return mpvf_pkg::sample_t'(v);
    endfunction

    function automatic mpvf_pkg::sample_t ring_median(int axis);
        mpvf_pkg::sample_t sorted [mpvf_pkg::WINDOW_LEN];
        mpvf_pkg::sample_t key;
        int                j;
        for (int i = 0; i < mpvf_pkg::WINDOW_LEN; i++)
            sorted[i] = ring[axis][i];
        for (int i = 1; i < mpvf_pkg::WINDOW_LEN; i++)
        begin
            key = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > key)
            begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = key;
        end
        return sorted[mpvf_pkg::WINDOW_LEN / 2];
    endfunction

    function automatic estimate_t predict_estimate(table_row_t row);
        estimate_t         e;
        mpvf_pkg::sample_t pos [mpvf_pkg::AXES];
        mpvf_pkg::sample_t med;
        mpvf_pkg::sample_t raw;
        longint            w;
        longint            acc;
        pos[0] = row.x;
        pos[1] = row.y;
        pos[2] = row.h;
        w = (weight_reg > mpvf_pkg::WEIGHT_FULL) ? 64'sd256 : longint'(weight_reg);
        if (ring_slot >= mpvf_pkg::WINDOW_LEN)
            ring_slot = 0;
        for (int a = 0; a < mpvf_pkg::AXES; a++)
            ring[a][ring_slot] = pos[a];
        ring_slot = (ring_slot + 1 >= mpvf_pkg::WINDOW_LEN) ? 0 : ring_slot + 1;
        for (int a = 0; a < mpvf_pkg::AXES; a++)
        begin
            med = ring_median(a);
            raw = clamp24(longint'(med) - longint'(last_median[a]));
            acc = w * longint'(raw) + (64'sd256 - w) * longint'(last_velocity[a]) + 64'sd128;
            e.med[a] = med;
            e.vel[a] = clamp24(acc >>> 8);
            last_median[a] = med;
            last_velocity[a] = e.vel[a];
        end
        return e;
    endfunction

    task automatic wait_idle();
        while (samples_accepted != samples_queued || estimate_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_weight(input mpvf_pkg::weight_t value);
        cfg.smoothing_weight <= value;
        cfg.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg.ready);
        weight_reg = value;
        cfg.valid <= 1'b0;
    endtask

    initial
    begin : sample_driver
        table_row_t row;
        estimate_t  predicted;
        int         gap;
        gap = 0;
        row = '0;
        samp.valid <= 1'b0;
        samp.x_position <= '0;
        samp.y_position <= '0;
        samp.heading_angle <= '0;
        forever
        begin
            @(posedge clk);
            if (samp.valid && samp.ready)
            begin
                predicted = predict_estimate(row);
                estimate_queue.push_back(row.at_rest ? estimate_t'('0) : predicted);
                samples_accepted++;
            end
            else if (samp.valid)
                continue;
            if (gap > 0)
            begin
                gap--;
                samp.valid <= 1'b0;
            end
            else if (sample_queue.size() != 0)
            begin
                row = sample_queue.pop_front();
                samp.x_position <= row.x;
                samp.y_position <= row.y;
                samp.heading_angle <= row.h;
                samp.valid <= 1'b1;
                if (!steady && $urandom_range(99) < idle_pct)
                    gap = $urandom_range(14, 1);
            end
            else
                samp.valid <= 1'b0;
        end
    end

    initial
    begin : estimate_sink
        int hold;
        hold = 0;
        est.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                est.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(99) < idle_pct)
            begin
                hold = $urandom_range(13, 0);
                est.ready <= 1'b0;
            end
            else
                est.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_estimates
        estimate_t got;
        estimate_t want;
        if (rst_n && est.valid && est.ready)
        begin
            got.med[0] = est.x_median;
            got.med[1] = est.y_median;
            got.med[2] = est.heading_median;
            got.vel[0] = est.x_velocity;
            got.vel[1] = est.y_velocity;
            got.vel[2] = est.heading_rate;
            if (estimate_queue.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected estimate item: %h", got);
            end
            else
            begin
                want = estimate_queue.pop_front();
                for (int a = 0; a < mpvf_pkg::AXES; a++)
                begin
                    if (got.med[a] !== want.med[a])
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("axis %0d median: expected %0d got %0d",
                                     a, signed'(want.med[a]), signed'(got.med[a]));
                    end
                    if (got.vel[a] !== want.vel[a])
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("axis %0d velocity: expected %0d got %0d",
                                     a, signed'(want.vel[a]), signed'(got.vel[a]));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (samp.valid && samp.ready) || (est.valid && est.ready)
            || (cfg.valid && cfg.ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("tb_median_position_velocity_filter NOT OK");
            $finish;
        end
    end

    initial
    begin : run
        mpvf_pkg::weight_t phase_weight [PHASES];
        mpvf_pkg::sample_t walk_base [mpvf_pkg::AXES];
        mpvf_pkg::sample_t v;
        mpvf_pkg::sample_t picked [mpvf_pkg::AXES];
        table_row_t        row;
        sample_style_t     style;
        int                burst_left;
        int                pick;
        for (int a = 0; a < mpvf_pkg::AXES; a++)
        begin
            for (int i = 0; i < mpvf_pkg::WINDOW_LEN; i++)
                ring[a][i] = '0;
            last_median[a] = '0;
            last_velocity[a] = '0;
            walk_base[a] = mpvf_pkg::sample_t'($urandom());
        end
        ring_slot = 0;
        weight_reg = mpvf_pkg::WEIGHT_RST;
        samples_queued = 0;
        samples_accepted = 0;
        error_count = 0;
        idle_pct = 30;
        steady = 1'b0;
        stalled_cycles = 0;
        burst_left = 0;
        style = STYLE_WALK;
        rst_n <= 1'b0;
        cfg.valid <= 1'b0;
        cfg.smoothing_weight <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            sample_queue.push_back(DIRECTED[i]);
        samples_queued += DIRECTED_ROWS;

        phase_weight = '{mpvf_pkg::WEIGHT_FULL, mpvf_pkg::weight_t'(0),
                         mpvf_pkg::weight_t'(511), mpvf_pkg::weight_t'(300),
                         mpvf_pkg::weight_t'(1), mpvf_pkg::weight_t'(255),
                         mpvf_pkg::weight_t'(128),
                         mpvf_pkg::weight_t'($urandom_range(511))};

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_weight(phase_weight[p]);
            steady = (p == PHASES - 1);
            case ($urandom_range(3))
                0: idle_pct = 0;
                1: idle_pct = 15;
                2: idle_pct = 40;
                default: idle_pct = 70;
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (burst_left == 0)
                begin
                    pick = $urandom_range(9);
                    if (pick < 2)
                        style = STYLE_NOISE;
                    else if (pick < 5)
                        style = STYLE_WALK;
                    else if (pick < 8)
                        style = STYLE_SPIKY_WALK;
                    else
                        style = STYLE_EXTREME;
                    burst_left = $urandom_range(30, 5);
                end
                burst_left--;
                for (int a = 0; a < mpvf_pkg::AXES; a++)
                begin
                    walk_base[a] = walk_base[a]
                                 + mpvf_pkg::sample_t'(int'($urandom_range(2000)) - 1000);
                    case (style)
                        STYLE_NOISE: v = mpvf_pkg::sample_t'($urandom());
                        STYLE_WALK: v = walk_base[a];
                        STYLE_SPIKY_WALK:
                            v = ($urandom_range(7) == 0) ? mpvf_pkg::sample_t'($urandom())
                                                         : walk_base[a];
                        default:
                        begin
                            case ($urandom_range(4))
                                0: v = mpvf_pkg::sample_t'(SAT_HI);
                                1: v = mpvf_pkg::sample_t'(SAT_LO);
                                2: v = '0;
                                3: v = '1;
                                default: v = mpvf_pkg::sample_t'(1);
                            endcase
                        end
                    endcase
                    picked[a] = v;
                end
                row.at_rest = 1'b0;
                row.x = picked[0];
                row.y = picked[1];
                row.h = picked[2];
                sample_queue.push_back(row);
            end
            samples_queued += PHASE_ITEMS;
        end

        wait_idle();
        if (error_count == 0 && estimate_queue.size() == 0)
            $display("tb_median_position_velocity_filter OK");
        else
            $display("tb_median_position_velocity_filter NOT OK");
        $finish;
    end

endmodule
